### rtl/core/ppe_pkg.sv
// ppe_pkg: shared types, constants and the butterfly network function
// for the polar pre-transform encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

    localparam int CODE_LEN = 64;                  // codeword length, 2..64
    localparam int WORD_W   = 64;                  // width of the wide payload fields
    localparam int POS_W    = 6;                   // width of a codeword position
    localparam int INFO_W   = 6;                   // width of an info bit index
    localparam int LANE_W   = $clog2(CODE_LEN);    // index into the lanes
    localparam int STAGES   = $clog2(CODE_LEN);    // butterfly levels, zero-size ones skipped

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_ENCODE = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_FROZEN  = 1'b0,
        CFG_DYNAMIC = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic code_bit;   // value of this position before the butterfly
        logic missing;    // dynamic frozen position without a loaded row
    } lane_out_t;

    // polar butterfly, x[j+i] ^= x[j+k+i] for k = N/2, N/4, ..., 1
    function automatic logic [CODE_LEN-1:0] butterfly(input logic [CODE_LEN-1:0] x_in);
        logic [CODE_LEN-1:0] x;
        int                  k;
        x = x_in;
        for (int s = 0; s < STAGES; s++) begin
            k = CODE_LEN >> (s + 1);
            if (k > 0) begin
                for (int j = 0; j < CODE_LEN; j += 2 * k) begin
                    for (int i = 0; i < k; i++) begin
                        if (j + k + i < CODE_LEN) begin
                            x[j + i] = x[j + i] ^ x[j + k + i];
                        end
                    end
                end
            end
        end
        return x;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ppe_lane.sv
// ppe_lane: one codeword position; holds its pre-transform row and valid mark
// and forms the position's bit for an encode beat; uses ppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppe_lane (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       row_we,
    input  wire logic [ppe_pkg::WORD_W-1:0] row_select,
    input  wire logic [ppe_pkg::WORD_W-1:0] info_bits,
    input  wire logic [ppe_pkg::INFO_W-1:0] info_idx,
    input  wire logic                       frozen_bit,
    input  wire logic                       dynamic_bit,
    output ppe_pkg::lane_out_t              lane_out
);
    import ppe_pkg::*;

    logic [WORD_W-1:0] row_reg;
    logic              loaded_reg;
    logic              loaded_next;

    assign loaded_next = row_we ? 1'b1 : loaded_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
        end else begin
            loaded_reg <= loaded_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_reg <= row_select;
        end
    end

    always_comb begin
        lane_out = '0;
        if (frozen_bit) begin
            if (dynamic_bit) begin
                if (loaded_reg) begin
                    lane_out.code_bit = ^(info_bits & row_reg);
                end else begin
                    lane_out.missing = 1'b1;
                end
            end
        end else begin
            lane_out.code_bit = info_bits[info_idx];
        end
    end

endmodule

`default_nettype wire

### rtl/core/ppe_idx_walk.sv
// ppe_idx_walk: walks the frozen mask once per change and records, for each
// non-frozen position, which info bit it takes; uses ppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppe_idx_walk (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         restart,
    input  wire logic [ppe_pkg::WORD_W-1:0]   frozen_mask,
    output logic                              busy,
    output logic [ppe_pkg::INFO_W-1:0]        info_idx [ppe_pkg::CODE_LEN]
);
    import ppe_pkg::*;

    logic                busy_reg, busy_next;
    logic [LANE_W-1:0]   pos_reg, pos_next;
    logic [INFO_W:0]     cnt_reg, cnt_next;
    logic [INFO_W-1:0]   idx_reg [CODE_LEN];

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        if (restart) begin
            busy_next = 1'b1;
            pos_next  = '0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (!frozen_mask[pos_reg]) begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (pos_reg == LANE_W'(CODE_LEN - 1)) begin
                busy_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // reset starts a walk so the index table matches the cleared mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !restart) begin
            idx_reg[pos_reg] <= cnt_reg[INFO_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign info_idx = idx_reg;

endmodule

`default_nettype wire

### rtl/core/ppe_merge.sv
// ppe_merge: gathers the lane results into a frame register, runs the
// butterfly and holds the result beat; uses ppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppe_merge (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ppe_pkg::lane_out_t           lane_out [ppe_pkg::CODE_LEN],
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ppe_pkg::WORD_W-1:0]        codeword,
    output logic                              missing_row_error
);
    import ppe_pkg::*;

    logic                v1_reg, v1_next;
    logic                ov_reg, ov_next;
    logic                advance;
    logic                take;
    logic [CODE_LEN-1:0] x_in;
    logic                miss_in;
    logic [CODE_LEN-1:0] x_reg;
    logic                miss_reg;
    logic [WORD_W-1:0]   cw_reg;
    logic                err_reg;

    always_comb begin
        x_in    = '0;
        miss_in = 1'b0;
        for (int i = 0; i < CODE_LEN; i++) begin
            x_in[i] = lane_out[i].code_bit;
            miss_in = miss_in | lane_out[i].missing;
        end
    end

    assign advance  = v1_reg && (!ov_reg || out_ready);
    assign in_ready = !v1_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb begin
        v1_next = v1_reg;
        if (take) begin
            v1_next = 1'b1;
        end else if (advance) begin
            v1_next = 1'b0;
        end
        ov_next = ov_reg;
        if (advance) begin
            ov_next = 1'b1;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg    <= x_in;
            miss_reg <= miss_in;
        end
        if (advance) begin
            // a missing row zeroes the whole codeword
            cw_reg  <= miss_reg ? '0 : WORD_W'(butterfly(x_reg));
            err_reg <= miss_reg;
        end
    end

    assign out_valid         = ov_reg;
    assign codeword          = cw_reg;
    assign missing_row_error = err_reg;

endmodule

`default_nettype wire

### rtl/core/polar_pretransform_encoder.sv
// Polar encoder with dynamically frozen bits.
// Input channel s_*: one beat is either a row load (s_cmd = load) that stores
// s_row_select as the pre-transform row of position s_row_position, or an
// encode (s_cmd = encode) of the frame in s_info_bits. Loads give no result.
// Result channel m_*: one beat per encode, m_codeword and m_missing_row_error.
// If a dynamically frozen position has no loaded row the codeword is zero and
// the error flag is set.
// Configuration: cfg_wr_en writes cfg_wdata into frozen_mask or dynamic_mask.
// The lane bits of an accepted encode are captured in the frame register and
// the butterfly result then in the result register that holds the m_* beat.
// Throughput: one beat per cycle while s_ready is high, all positions at once.
// After reset and after every frozen_mask write, the info index table is
// rebuilt by a walk over the positions, one per cycle, with s_ready low.
// Reset clears both masks and every row's valid mark.
// When the receiver stalls, the result register and the lane stage hold and
// s_ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module polar_pretransform_encoder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire ppe_pkg::cfg_idx_t            cfg_addr,
    input  wire logic [ppe_pkg::WORD_W-1:0]   cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_cmd,
    input  wire logic [ppe_pkg::POS_W-1:0]    s_row_position,
    input  wire logic [ppe_pkg::WORD_W-1:0]   s_row_select,
    input  wire logic [ppe_pkg::WORD_W-1:0]   s_info_bits,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [ppe_pkg::WORD_W-1:0]        m_codeword,
    output logic                              m_missing_row_error
);
    import ppe_pkg::*;

    logic [WORD_W-1:0] frozen_mask_reg, frozen_mask_next;
    logic [WORD_W-1:0] dynamic_mask_reg, dynamic_mask_next;
    logic              walk_busy;
    logic              walk_restart;
    logic [INFO_W-1:0] info_idx [CODE_LEN];
    logic              enc_ready;
    logic              accept;
    logic              load_beat;
    logic              enc_beat;
    lane_out_t         lane_out [CODE_LEN];

    always_comb begin
        frozen_mask_next  = frozen_mask_reg;
        dynamic_mask_next = dynamic_mask_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FROZEN:  frozen_mask_next  = cfg_wdata;
                CFG_DYNAMIC: dynamic_mask_next = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frozen_mask_reg  <= '0;
            dynamic_mask_reg <= '0;
        end else begin
            frozen_mask_reg  <= frozen_mask_next;
            dynamic_mask_reg <= dynamic_mask_next;
        end
    end

    assign walk_restart = cfg_wr_en && (cfg_addr == CFG_FROZEN);

    ppe_idx_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (walk_restart),
        .frozen_mask (frozen_mask_reg),
        .busy        (walk_busy),
        .info_idx    (info_idx)
    );

    assign s_ready   = !walk_busy && enc_ready;
    assign accept    = s_valid && s_ready;
    assign load_beat = accept && (s_cmd == CMD_LOAD);
    assign enc_beat  = accept && (s_cmd == CMD_ENCODE);

    for (genvar g = 0; g < CODE_LEN; g++) begin : g_lane
        ppe_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .row_we      (load_beat && (s_row_position == POS_W'(g))),
            .row_select  (s_row_select),
            .info_bits   (s_info_bits),
            .info_idx    (info_idx[g]),
            .frozen_bit  (frozen_mask_reg[g]),
            .dynamic_bit (dynamic_mask_reg[g]),
            .lane_out    (lane_out[g])
        );
    end

    ppe_merge u_merge (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (enc_beat),
        .in_ready          (enc_ready),
        .lane_out          (lane_out),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .codeword          (m_codeword),
        .missing_row_error (m_missing_row_error)
    );

endmodule

`default_nettype wire

### rtl/core/ppe_checker.sv
// ppe_checker: port-level checks of the polar pre-transform encoder, bound to
// the top level; uses ppe_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppe_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [ppe_pkg::WORD_W-1:0] m_codeword,
    input wire logic                       m_missing_row_error
);
    import ppe_pkg::*;

    // no result beat can appear right out of reset
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // the index walk runs after reset, so no beat is taken
    a_reset_walk: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during post-reset walk");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_missing_row_error) |-> (m_codeword == '0))
        else $error("error beat with nonzero codeword");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_codeword) && $stable(m_missing_row_error)))
        else $error("result beat changed while stalled");

endmodule

bind polar_pretransform_encoder ppe_checker u_ppe_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_codeword          (m_codeword),
    .m_missing_row_error (m_missing_row_error)
);

`default_nettype wire
